// ===== hdl/rrwt_pkg.sv =====
// ============================================================================
// rrwt_pkg: shared types and constants for the round-robin wait time block
// Field widths, sequencer states and the shared ALU op codes and flags.
// ============================================================================
`default_nettype none

package rrwt_pkg;

   // Field widths
   localparam int BURST_W   = 16;
   localparam int INDEX_W   = 5;
   localparam int WAIT_W    = 21;
   localparam int TOTAL_W   = 26;
   localparam int ALU_W     = 26;

   // Defaults
   localparam int              MAX_PROCS_DEFAULT = 32;
   localparam logic [BURST_W-1:0] QUANTUM_RESET  = 16'd1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SIM_RD,
      ST_SIM_SUB,
      ST_SIM_ADD,
      ST_SIM_FIN,
      ST_SIM_NEXT,
      ST_OUT_RD,
      ST_OUT_TURN,
      ST_OUT_TOTW,
      ST_OUT_TOTT,
      ST_OUT_SEND
   } rrwt_state_type;

   // Shared ALU operations
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Shared ALU status
   typedef struct packed {
      logic borrow;
      logic zero;
   } alu_flags_type;

endpackage : rrwt_pkg

`default_nettype wire

// ===== hdl/rrwt_ifs.sv =====
// ============================================================================
// rrwt_ifs: valid/ready channels of the round-robin wait time block
// Burst input, per-process result output and quantum register write.
// ============================================================================
`default_nettype none

// Burst input channel
interface rrwt_req_if import rrwt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BURST_W-1:0] burst;
   logic               last;

   modport source (output valid, output burst, output last, input ready);
   modport sink   (input valid, input burst, input last, output ready);
endinterface : rrwt_req_if

// Per-process result channel
interface rrwt_rsp_if import rrwt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] process_index;
   logic [WAIT_W-1:0]  waiting_time;
   logic [WAIT_W-1:0]  turnaround_time;
   logic [TOTAL_W-1:0] total_waiting;
   logic [TOTAL_W-1:0] total_turnaround;
   logic               dropped;
   logic               final_res;

   modport source (output valid, output process_index, output waiting_time,
                   output turnaround_time, output total_waiting,
                   output total_turnaround, output dropped, output final_res,
                   input ready);
   modport sink   (input valid, input process_index, input waiting_time,
                   input turnaround_time, input total_waiting,
                   input total_turnaround, input dropped, input final_res,
                   output ready);
endinterface : rrwt_rsp_if

// Quantum register write channel
interface rrwt_csr_if import rrwt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BURST_W-1:0] time_quantum;

   modport source (output valid, output time_quantum, input ready);
   modport sink   (input valid, input time_quantum, output ready);
endinterface : rrwt_csr_if

`default_nettype wire

// ===== hdl/rrwt_ram.sv =====
// ============================================================================
// rrwt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module rrwt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule : rrwt_ram

`default_nettype wire

// ===== hdl/rrwt_alu.sv =====
// ============================================================================
// rrwt_alu: shared add/subtract unit
// One adder shared by the add and subtract steps of the round-robin sequencer.
// ============================================================================
`default_nettype none

module rrwt_alu import rrwt_pkg::*; (
   input  wire logic [ALU_W-1:0] a,
   input  wire logic [ALU_W-1:0] b,
   input  wire alu_op_type       op,
   output logic      [ALU_W-1:0] result,
   output alu_flags_type         flags
);

   logic [ALU_W:0] sum;

   // Add or subtract with carry out as borrow
   always_comb begin
      case (op)
         ALU_ADD: sum = {1'b0, a} + {1'b0, b};
         ALU_SUB: sum = {1'b0, a} - {1'b0, b};
         default: sum = {1'b0, a} + {1'b0, b};
      endcase
   end

   assign result       = sum[ALU_W-1:0];
   assign flags.borrow = (op == ALU_SUB) && sum[ALU_W];
   assign flags.zero   = (sum[ALU_W-1:0] == '0);

endmodule : rrwt_alu

`default_nettype wire

// ===== hdl/round_robin_wait_times.sv =====
// ============================================================================
// round_robin_wait_times: round-robin scheduling wait time calculator
// Loads bursts, simulates round-robin service and streams per-process times.
// ============================================================================
// Loading: one burst transaction per cycle while ready.
// Simulation after the last transaction, per process and pass: RD, SUB, NEXT
// if finished, with ADD for a partial slice and ADD, FIN for the finishing
// slice; passes run ceil(largest burst / quantum) times plus one closing pass
// with all done. Results: RD, TURN, TOTW, TOTT, then SEND held under output
// stall; ready returns after the final result. Synchronous active-high reset
// clears counters and state, sets the quantum to 1; memories need no clearing.
`default_nettype none

module round_robin_wait_times import rrwt_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   rrwt_req_if.sink   req_if,
   rrwt_rsp_if.source rsp_if,
   rrwt_csr_if.sink   csr_if
);

   localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int TW = BURST_W + $clog2(MAX_PROCS);

   rrwt_state_type     state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               busy_ff, busy_in;
   logic               overflow_ff, overflow_in;
   logic               finishing_ff, finishing_in;
   logic [BURST_W-1:0] quantum_ff;
   logic [BURST_W-1:0] step_ff, step_in;
   logic [TW-1:0]      elapsed_ff, elapsed_in;
   logic [TW-1:0]      wait_ff, wait_in;
   logic [TW-1:0]      turn_ff, turn_in;
   logic [TOTAL_W-1:0] tot_w_ff, tot_w_in;
   logic [TOTAL_W-1:0] tot_t_ff, tot_t_in;

   logic [BURST_W-1:0] quantum;
   logic               req_acc;
   logic               load_we;
   logic               idx_last;

   logic [AW-1:0]      wr_addr;
   logic               rem_we;
   logic [BURST_W-1:0] rem_wdata;
   logic               fin_we;
   logic [TW-1:0]      fin_wdata;
   logic [BURST_W-1:0] orig_rd;
   logic [BURST_W-1:0] rem_rd;
   logic [TW-1:0]      fin_rd;

   logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
   alu_op_type         alu_op;
   alu_flags_type      alu_flags;

   logic [31:0]        idx_ext;
   logic [ALU_W-1:0]   wait_ext, turn_ext;

   // Effective quantum: zero acts as one
   assign quantum  = (quantum_ff == '0) ? BURST_W'(1) : quantum_ff;
   assign req_acc  = req_if.valid && req_if.ready;
   assign load_we  = req_acc && (cnt_ff < CW'(MAX_PROCS));
   assign idx_last = ((CW'(idx_ff) + CW'(1)) == cnt_ff);

   // Quantum register
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_if.valid) begin
         quantum_ff <= csr_if.time_quantum;
      end
   end

   // Burst memories
   assign wr_addr   = (state_ff == ST_LOAD) ? cnt_ff[AW-1:0] : idx_ff;
   assign rem_we    = load_we || ((state_ff == ST_SIM_SUB) && (rem_rd != '0));
   assign fin_we    = load_we || (state_ff == ST_SIM_FIN);
   assign rem_wdata = (state_ff == ST_LOAD) ? req_if.burst :
                      (finishing_in ? '0 : alu_res[BURST_W-1:0]);
   assign fin_wdata = (state_ff == ST_LOAD) ? '0 : alu_res[TW-1:0];

   rrwt_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCS)) u_orig_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_if.burst),
      .rd_addr (idx_ff),
      .rd_data (orig_rd)
   );

   rrwt_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (wr_addr),
      .wr_data (rem_wdata),
      .rd_addr (idx_ff),
      .rd_data (rem_rd)
   );

   rrwt_ram #(.WIDTH(TW), .DEPTH(MAX_PROCS)) u_fin_ram (
      .clock   (clock),
      .wr_en   (fin_we),
      .wr_addr (wr_addr),
      .wr_data (fin_wdata),
      .rd_addr (idx_ff),
      .rd_data (fin_rd)
   );

   // Shared adder
   rrwt_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .op     (alu_op),
      .result (alu_res),
      .flags  (alu_flags)
   );

   // Select adder operands by step
   always_comb begin
      alu_a  = '0;
      alu_b  = '0;
      alu_op = ALU_ADD;
      case (state_ff)
         ST_SIM_SUB: begin
            alu_a  = ALU_W'(rem_rd);
            alu_b  = ALU_W'(quantum);
            alu_op = ALU_SUB;
         end
         ST_SIM_ADD: begin
            alu_a = ALU_W'(elapsed_ff);
            alu_b = ALU_W'(step_ff);
         end
         ST_SIM_FIN: begin
            alu_a  = ALU_W'(elapsed_ff);
            alu_b  = ALU_W'(orig_rd);
            alu_op = ALU_SUB;
         end
         ST_OUT_TURN: begin
            alu_a = ALU_W'(orig_rd);
            alu_b = ALU_W'(fin_rd);
         end
         ST_OUT_TOTW: begin
            alu_a = ALU_W'(tot_w_ff);
            alu_b = ALU_W'(wait_ff);
         end
         ST_OUT_TOTT: begin
            alu_a = ALU_W'(tot_t_ff);
            alu_b = ALU_W'(turn_ff);
         end
         default: begin
            alu_a  = '0;
            alu_b  = '0;
            alu_op = ALU_ADD;
         end
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         idx_ff      <= '0;
         busy_ff     <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
         busy_ff     <= busy_in;
         overflow_ff <= overflow_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      finishing_ff <= finishing_in;
      step_ff      <= step_in;
      elapsed_ff   <= elapsed_in;
      wait_ff      <= wait_in;
      turn_ff      <= turn_in;
      tot_w_ff     <= tot_w_in;
      tot_t_ff     <= tot_t_in;
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      overflow_in  = overflow_ff;
      finishing_in = finishing_ff;
      step_in      = step_ff;
      elapsed_in   = elapsed_ff;
      wait_in      = wait_ff;
      turn_in      = turn_ff;
      tot_w_in     = tot_w_ff;
      tot_t_in     = tot_t_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (load_we) begin
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_if.last) begin
                  state_in   = ST_SIM_RD;
                  idx_in     = '0;
                  busy_in    = 1'b0;
                  elapsed_in = '0;
                  tot_w_in   = '0;
                  tot_t_in   = '0;
               end
            end
         end
         ST_SIM_RD: begin
            state_in = ST_SIM_SUB;
         end
         ST_SIM_SUB: begin
            // Skip finished processes, else take one slice
            if (rem_rd == '0) begin
               state_in = ST_SIM_NEXT;
            end else begin
               busy_in = 1'b1;
               if (!alu_flags.borrow && !alu_flags.zero) begin
                  finishing_in = 1'b0;
                  step_in      = quantum;
               end else begin
                  finishing_in = 1'b1;
                  step_in      = rem_rd;
               end
               state_in = ST_SIM_ADD;
            end
         end
         ST_SIM_ADD: begin
            elapsed_in = alu_res[TW-1:0];
            state_in   = finishing_ff ? ST_SIM_FIN : ST_SIM_NEXT;
         end
         ST_SIM_FIN: begin
            state_in = ST_SIM_NEXT;
         end
         ST_SIM_NEXT: begin
            // Advance index, start a new pass or move to results
            if (idx_last) begin
               idx_in = '0;
               if (busy_ff) begin
                  busy_in  = 1'b0;
                  state_in = ST_SIM_RD;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_SIM_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_TURN;
         end
         ST_OUT_TURN: begin
            wait_in  = fin_rd;
            turn_in  = alu_res[TW-1:0];
            state_in = ST_OUT_TOTW;
         end
         ST_OUT_TOTW: begin
            tot_w_in = alu_res[TOTAL_W-1:0];
            state_in = ST_OUT_TOTT;
         end
         ST_OUT_TOTT: begin
            tot_t_in = alu_res[TOTAL_W-1:0];
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            // Hold the result until taken, then drop the set after the last
            if (rsp_if.ready) begin
               if (idx_last) begin
                  idx_in      = '0;
                  cnt_in      = '0;
                  overflow_in = 1'b0;
                  elapsed_in  = '0;
                  state_in    = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Handshakes and result fields
   assign req_if.ready = (state_ff == ST_LOAD);
   assign rsp_if.valid = (state_ff == ST_OUT_SEND);

   assign idx_ext  = 32'(idx_ff);
   assign wait_ext = ALU_W'(wait_ff);
   assign turn_ext = ALU_W'(turn_ff);

   assign rsp_if.process_index    = idx_ext[INDEX_W-1:0];
   assign rsp_if.waiting_time     = wait_ext[WAIT_W-1:0];
   assign rsp_if.turnaround_time  = turn_ext[WAIT_W-1:0];
   assign rsp_if.total_waiting    = tot_w_ff;
   assign rsp_if.total_turnaround = tot_t_ff;
   assign rsp_if.dropped          = overflow_ff;
   assign rsp_if.final_res        = idx_last;

   // Checks
   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("input ready while a result is pending");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PROCS))
      else $error("loaded count beyond capacity");

   a_idx_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (CW'(idx_ff) < cnt_ff))
      else $error("process index outside the loaded set");

   a_empty_after_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.final_res) |=>
         (cnt_ff == '0 && !overflow_ff && req_if.ready))
      else $error("set not cleared after the final result");

   a_elapsed_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIM_ADD) |=>
         (elapsed_ff == TW'($past(elapsed_ff) + TW'($past(step_ff)))))
      else $error("elapsed time not advanced by the slice");

endmodule : round_robin_wait_times

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking testbench for round_robin_wait_times
// Sends sets of process bursts and quantum register writes under random
// stalls on both channels, computes the expected round-robin wait and
// turnaround times of each set and compares every result transaction.
// ============================================================================

module tb_top import rrwt_pkg::*; ();

   localparam int              PROCS        = MAX_PROCS_DEFAULT;
   localparam int              STALL_PCT    = 32;
   localparam int              DRAIN_GAP    = 16;
   localparam int              TOTAL_ITEMS  = 360;
   localparam longint unsigned CYCLE_LIMIT  = 4000000;

   typedef struct packed {
      logic [INDEX_W-1:0] process_index;
      logic [WAIT_W-1:0]  waiting_time;
      logic [WAIT_W-1:0]  turnaround_time;
      logic [TOTAL_W-1:0] total_waiting;
      logic [TOTAL_W-1:0] total_turnaround;
      logic               dropped;
      logic               final_res;
   } proc_times_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrwt_req_if req_ch ();
   rrwt_rsp_if rsp_ch ();
   rrwt_csr_if csr_ch ();

   round_robin_wait_times #(.MAX_PROCS(PROCS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Scheduler shadow: quantum and the set being loaded
   logic [BURST_W-1:0] quantum_shadow;
   logic [BURST_W-1:0] loaded_bursts [PROCS];
   int unsigned        loaded_total;
   bit                 lost_items;
   proc_times_type     expected_times [$];

   int unsigned     fail_count  = 0;
   int unsigned     items_sent  = 0;
   longint unsigned cycle_count = 0;
   bit              req_stalls  = 1'b1;
   bit              rsp_stalls  = 1'b1;

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Record one accepted burst; on the last one, schedule the set and queue its times
   function automatic void predict_burst(logic [BURST_W-1:0] b, logic lst);
      int unsigned slice, clock_now, tot_w, tot_t, w, t;
      int unsigned left [PROCS];
      int unsigned done_wait [PROCS];
      bit          busy;
      proc_times_type r;
      if (loaded_total < PROCS) begin
         loaded_bursts[loaded_total] = b;
         loaded_total++;
      end else begin
         lost_items = 1'b1;
      end
      if (!lst) return;

      slice = (quantum_shadow == '0) ? 1 : int'(quantum_shadow);
      clock_now = 0;
      for (int i = 0; i < loaded_total; i++) begin
         left[i]      = loaded_bursts[i];
         done_wait[i] = 0;
      end
      // Pass over the processes until every one has finished
      busy = 1'b1;
      while (busy) begin
         busy = 1'b0;
         for (int i = 0; i < loaded_total; i++) begin
            if (left[i] != 0) begin
               busy = 1'b1;
               if (left[i] > slice) begin
                  clock_now += slice;
                  left[i]   -= slice;
               end else begin
                  clock_now    += left[i];
                  done_wait[i]  = clock_now - loaded_bursts[i];
                  left[i]       = 0;
               end
            end
         end
      end

      tot_w = 0;
      tot_t = 0;
      for (int i = 0; i < loaded_total; i++) begin
         w = (loaded_bursts[i] != '0) ? done_wait[i] : 0;
         t = (loaded_bursts[i] != '0) ? loaded_bursts[i] + w : 0;
         tot_w += w;
         tot_t += t;
         r.process_index    = INDEX_W'(i);
         r.waiting_time     = WAIT_W'(w);
         r.turnaround_time  = WAIT_W'(t);
         r.total_waiting    = TOTAL_W'(tot_w);
         r.total_turnaround = TOTAL_W'(tot_t);
         r.dropped          = lost_items;
         r.final_res        = (i + 1 == loaded_total);
         expected_times.push_back(r);
      end
      loaded_total = 0;
      lost_items   = 1'b0;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Result sink: random backpressure
   always @(negedge clock) begin
      rsp_ch.ready = !(rsp_stalls && ($urandom_range(0, 99) < STALL_PCT));
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      proc_times_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_times.size() == 0) begin
            $error("result for process %0d with no expectation", rsp_ch.process_index);
            fail_count++;
         end else begin
            want = expected_times.pop_front();
            check_field("process_index", want.process_index, rsp_ch.process_index);
            check_field("waiting_time", want.waiting_time, rsp_ch.waiting_time);
            check_field("turnaround_time", want.turnaround_time, rsp_ch.turnaround_time);
            check_field("total_waiting", want.total_waiting, rsp_ch.total_waiting);
            check_field("total_turnaround", want.total_turnaround,
                        rsp_ch.total_turnaround);
            check_field("dropped", want.dropped, rsp_ch.dropped);
            check_field("final_res", want.final_res, rsp_ch.final_res);
         end
      end
   end

   // Send one burst transaction, with random idle cycles ahead of it
   task automatic send_burst(input logic [BURST_W-1:0] b, input logic lst);
      @(negedge clock);
      while (req_stalls && ($urandom_range(0, 99) < STALL_PCT)) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.burst = b;
      req_ch.last  = lst;
      do @(posedge clock); while (!req_ch.ready);
      predict_burst(b, lst);
      items_sent++;
   endtask

   // Send a whole set, last flag on its final burst, then drop valid
   task automatic send_set(input logic [BURST_W-1:0] bursts [$]);
      for (int k = 0; k < bursts.size(); k++) begin
         send_burst(bursts[k], k == bursts.size() - 1);
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Hold until every expected result has arrived and the block settles
   task automatic wait_drained();
      while (expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // Write the quantum register while the block is idle
   task automatic write_quantum(input logic [BURST_W-1:0] q);
      wait_drained();
      @(negedge clock);
      csr_ch.valid        = 1'b1;
      csr_ch.time_quantum = q;
      do @(posedge clock); while (!csr_ch.ready);
      quantum_shadow = q;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Build a random set; bursts stay within a few passes of the quantum
   task automatic send_random_set();
      logic [BURST_W-1:0] set_q [$];
      int unsigned        n, pick, passes, cap;
      pick = $urandom_range(0, 99);
      if (pick < 10) n = $urandom_range(PROCS - 2, PROCS + 4);
      else if (pick < 20) n = 1;
      else n = $urandom_range(2, 12);
      passes = $urandom_range(1, 8);
      cap = int'(quantum_shadow) * passes;
      if (cap > 65535 || cap == 0) cap = 65535;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 15) == 0) set_q.push_back(BURST_W'(cap));
         else set_q.push_back(BURST_W'($urandom_range(1, cap)));
      end
      send_set(set_q);
   endtask

   // Reset quantum of 1: single process and a short set
   task automatic test_reset_quantum();
      logic [BURST_W-1:0] set_q [$];
      set_q = '{16'd1};
      send_set(set_q);
      set_q = '{16'd2, 16'd1, 16'd3};
      send_set(set_q);
   endtask

   // Full capacity of maximum bursts, one extra item carrying the last flag
   task automatic test_capacity_overflow();
      logic [BURST_W-1:0] set_q [$];
      write_quantum(16'hFFFF);
      for (int k = 0; k <= PROCS; k++) set_q.push_back(16'hFFFF);
      send_set(set_q);
   endtask

   // Partial slices over several passes, then the smallest quantum
   task automatic test_partial_slices();
      logic [BURST_W-1:0] set_q [$];
      write_quantum(16'd3);
      set_q = '{16'd5, 16'd3, 16'd1, 16'd4, 16'd2};
      send_set(set_q);
      write_quantum(16'd1);
      set_q = '{16'd4, 16'd2};
      send_set(set_q);
   endtask

   // Back-to-back sets with no idle cycles on either side
   task automatic test_stream_no_stalls();
      req_stalls = 1'b0;
      rsp_stalls = 1'b0;
      write_quantum(BURST_W'($urandom_range(1, 64)));
      repeat (6) send_random_set();
      wait_drained();
      req_stalls = 1'b1;
      rsp_stalls = 1'b1;
   endtask

   // Random quanta and sets under random stalls, up to the item budget
   task automatic test_random_sets();
      int unsigned pick;
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0: write_quantum(16'd1);
            1: write_quantum(16'hFFFF);
            2: write_quantum(BURST_W'($urandom_range(1, 16)));
            default: write_quantum(BURST_W'($urandom_range(1, 65535)));
         endcase
         repeat ($urandom_range(3, 6)) begin
            send_random_set();
            if ($urandom_range(0, 7) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.burst        = '0;
      req_ch.last         = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.time_quantum = QUANTUM_RESET;
      quantum_shadow      = QUANTUM_RESET;
      loaded_total        = 0;
      lost_items          = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_quantum();
      test_capacity_overflow();
      test_partial_slices();
      test_stream_no_stalls();
      test_random_sets();

      wait_drained();
      if (fail_count == 0 && expected_times.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule : tb_top

// ===== sim.f =====
hdl/rrwt_pkg.sv
hdl/rrwt_ifs.sv
hdl/rrwt_ram.sv
hdl/rrwt_alu.sv
hdl/round_robin_wait_times.sv
tb/sv/tb_top.sv
